// ===== rtl/drc_pkg.sv =====
package drc_pkg;

	// Window geometry
	localparam int WINDOW_SIZE = 9;
	localparam int HALF_WIDTH  = (WINDOW_SIZE - 1) / 2;
	localparam int NORM_DENOM  = (HALF_WIDTH * (HALF_WIDTH + 1) * (2 * HALF_WIDTH + 1)) / 3;
	localparam int ROUND_HALF  = NORM_DENOM / 2;

	// Widths
	localparam int SAMPLE_W = 16;
	localparam int PTR_W    = $clog2(WINDOW_SIZE);
	localparam int FILL_W   = $clog2(WINDOW_SIZE + 1);
	localparam int TAP_W    = $clog2(HALF_WIDTH + 2);
	localparam int ACC_W    = $clog2((HALF_WIDTH * (HALF_WIDTH + 1) / 2) * 65536) + 2;
	localparam int MUL_W    = ACC_W + 1;
	localparam int PROD_W   = 2 * MUL_W;

	// Reciprocal of the normalizer, exact for every magnitude below 2^(ACC_W-1)
	localparam int RECIP_SHIFT = ACC_W - 1 + $clog2(NORM_DENOM);
	localparam longint unsigned RECIP_MULT =
		((64'd1 << RECIP_SHIFT) + 64'(NORM_DENOM) - 64'd1) / 64'(NORM_DENOM);

	// Output saturation bounds
	localparam int DELTA_MAX     = 32767;
	localparam int DELTA_MIN_MAG = 32768;

	// Opcodes
	localparam logic OP_PUSH    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Control from the sequencer to the shared unit
	typedef struct packed {
		logic acc_clr;
		logic acc_en;
		logic mul_tap;
		logic mag_en;
		logic mul_norm;
	} ctrl_t;

endpackage

// ===== rtl/drc_ram.sv =====
module drc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 9
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr_a,
	input  logic [$clog2(DEPTH)-1:0]   raddr_b,
	output logic [WIDTH-1:0]           rdata_a,
	output logic [WIDTH-1:0]           rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read two with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/drc_unit.sv =====
module drc_unit
	import drc_pkg::*;
(
	input  logic                       clk,
	input  ctrl_t                      ctrl,
	input  logic [TAP_W-1:0]           tap,
	input  logic signed [SAMPLE_W-1:0] rd_newer,
	input  logic signed [SAMPLE_W-1:0] rd_older,
	output logic signed [SAMPLE_W-1:0] delta_next
);

	logic signed [MUL_W-1:0]  diff;
	logic signed [MUL_W-1:0]  op_a;
	logic signed [MUL_W-1:0]  op_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  abs_acc;
	logic [ACC_W-1:0]         mag_q;
	logic                     neg_q;
	logic [PROD_W-1:0]        quot;

	// Select operands: tap weight times sample difference, or magnitude times reciprocal
	assign diff = MUL_W'(rd_newer) - MUL_W'(rd_older);

	always_comb begin
		if (ctrl.mul_norm) begin
			op_a = signed'({1'b0, mag_q});
			op_b = MUL_W'(RECIP_MULT);
		end else begin
			op_a = diff;
			op_b = MUL_W'(tap);
		end
	end

	// Shared multiplier with registered product
	always_ff @(posedge clk) begin
		if (ctrl.mul_tap || ctrl.mul_norm) begin
			prod_q <= op_a * op_b;
		end
	end

	// Accumulate weighted differences
	always_ff @(posedge clk) begin
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + signed'(prod_q[ACC_W-1:0]);
		end
	end

	// Take magnitude and add half the divisor for round to nearest
	assign abs_acc = acc_q[ACC_W-1] ? -acc_q : acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.mag_en) begin
			neg_q <= acc_q[ACC_W-1];
			mag_q <= ACC_W'(abs_acc) + ACC_W'(ROUND_HALF);
		end
	end

	// Drop the fraction, restore sign and saturate
	assign quot = prod_q >> RECIP_SHIFT;

	always_comb begin
		if (neg_q) begin
			if (quot >= PROD_W'(DELTA_MIN_MAG)) begin
				delta_next = signed'(SAMPLE_W'(DELTA_MIN_MAG));
			end else begin
				delta_next = signed'(SAMPLE_W'(0) - quot[SAMPLE_W-1:0]);
			end
		end else begin
			if (quot > PROD_W'(DELTA_MAX)) begin
				delta_next = signed'(SAMPLE_W'(DELTA_MAX));
			end else begin
				delta_next = signed'(quot[SAMPLE_W-1:0]);
			end
		end
	end

endmodule

// ===== rtl/drc_seq.sv =====
module drc_seq
	import drc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       opcode,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] delta,
	input  logic signed [SAMPLE_W-1:0] delta_next,
	output ctrl_t                      ctrl,
	output logic [TAP_W-1:0]           tap,
	output logic                       ram_we,
	output logic [PTR_W-1:0]           ram_waddr,
	output logic [PTR_W-1:0]           ram_raddr_newer,
	output logic [PTR_W-1:0]           ram_raddr_older
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RUN   = 5'b00010,
		ST_MAG   = 5'b00100,
		ST_SCALE = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t                     state_q;
	logic [PTR_W-1:0]           wr_pos_q;
	logic [FILL_W-1:0]          fill_q;
	logic [TAP_W-1:0]           step_q;
	logic [PTR_W-1:0]           newer_q;
	logic [PTR_W-1:0]           older_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] delta_q;
	logic                       accept;
	logic                       push;
	logic                       full_now;
	logic                       out_free;
	logic [PTR_W:0]             newer_sum;
	logic [PTR_W:0]             older_sum;
	logic [PTR_W-1:0]           newer_init;
	logic [PTR_W-1:0]           older_init;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign push      = accept && (opcode == OP_PUSH);
	assign full_now  = (fill_q >= FILL_W'(WINDOW_SIZE - 1));
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign delta     = delta_q;

	// First tap pair around the centre, HALF_WIDTH slots behind the newest sample
	assign newer_sum  = {1'b0, wr_pos_q} + (PTR_W + 1)'(WINDOW_SIZE - HALF_WIDTH + 1);
	assign older_sum  = {1'b0, wr_pos_q} + (PTR_W + 1)'(WINDOW_SIZE - HALF_WIDTH - 1);
	assign newer_init = (newer_sum >= (PTR_W + 1)'(WINDOW_SIZE))
		? PTR_W'(newer_sum - (PTR_W + 1)'(WINDOW_SIZE)) : PTR_W'(newer_sum);
	assign older_init = (older_sum >= (PTR_W + 1)'(WINDOW_SIZE))
		? PTR_W'(older_sum - (PTR_W + 1)'(WINDOW_SIZE)) : PTR_W'(older_sum);

	// Ring access
	assign ram_we          = push;
	assign ram_waddr       = wr_pos_q;
	assign ram_raddr_newer = newer_q;
	assign ram_raddr_older = older_q;

	// Control for the shared unit
	assign tap = step_q;

	always_comb begin
		ctrl          = '0;
		ctrl.acc_clr  = push && full_now;
		ctrl.mul_tap  = (state_q == ST_RUN) && (step_q >= TAP_W'(1))
			&& (step_q <= TAP_W'(HALF_WIDTH));
		ctrl.acc_en   = (state_q == ST_RUN) && (step_q >= TAP_W'(2));
		ctrl.mag_en   = (state_q == ST_MAG);
		ctrl.mul_norm = (state_q == ST_SCALE);
	end

	// Write position and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q <= '0;
			fill_q   <= '0;
		end else if (accept) begin
			if (opcode == OP_RESTART) begin
				wr_pos_q <= '0;
				fill_q   <= '0;
			end else begin
				wr_pos_q <= (wr_pos_q == PTR_W'(WINDOW_SIZE - 1)) ? '0 : wr_pos_q + 1'b1;
				if (fill_q < FILL_W'(WINDOW_SIZE)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			newer_q <= '0;
			older_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (push && full_now) begin
						state_q <= ST_RUN;
						step_q  <= '0;
						newer_q <= newer_init;
						older_q <= older_init;
					end
				end
				ST_RUN: begin
					// advance both taps outward from the centre
					newer_q <= (newer_q == PTR_W'(WINDOW_SIZE - 1)) ? '0 : newer_q + 1'b1;
					older_q <= (older_q == '0) ? PTR_W'(WINDOW_SIZE - 1) : older_q - 1'b1;
					if (step_q == TAP_W'(HALF_WIDTH + 1)) begin
						state_q <= ST_MAG;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_MAG: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			delta_q <= delta_next;
		end
	end

endmodule

// ===== rtl/delta_regression_coefficient.sv =====
// Regression delta over a sliding window of WINDOW_SIZE Q1.15 samples.
// A full-window push starts the sequencer: RUN weights the tap pairs, MAG takes the magnitude,
// SCALE applies the reciprocal and FIN registers delta once the output register is free.
// No new item is taken until FIN hands delta on, longer while the output stalls; pushes before
// the window fills and restarts skip the sequencer. The shared multiplier takes one tap pair per cycle, then the scale.
// Reset clears fill count, write position, sequencer and output valid; samples are kept.
module delta_regression_coefficient
	import drc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       opcode,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] delta
);

	ctrl_t                      ctrl;
	logic [TAP_W-1:0]           tap;
	logic                       ram_we;
	logic [PTR_W-1:0]           ram_waddr;
	logic [PTR_W-1:0]           ram_raddr_newer;
	logic [PTR_W-1:0]           ram_raddr_older;
	logic [SAMPLE_W-1:0]        rd_newer;
	logic [SAMPLE_W-1:0]        rd_older;
	logic signed [SAMPLE_W-1:0] delta_next;

	drc_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.delta           (delta),
		.delta_next      (delta_next),
		.ctrl            (ctrl),
		.tap             (tap),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_raddr_newer (ram_raddr_newer),
		.ram_raddr_older (ram_raddr_older)
	);

	drc_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (WINDOW_SIZE)
	) u_ring (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (sample),
		.raddr_a (ram_raddr_newer),
		.raddr_b (ram_raddr_older),
		.rdata_a (rd_newer),
		.rdata_b (rd_older)
	);

	drc_unit u_unit (
		.clk        (clk),
		.ctrl       (ctrl),
		.tap        (tap),
		.rd_newer   (signed'(rd_newer)),
		.rd_older   (signed'(rd_older)),
		.delta_next (delta_next)
	);

	// The sequencer holds off new items while the shared unit is busy
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.mul_tap || ctrl.mul_norm || ctrl.mag_en) |-> !in_ready)
		else $error("item accepted while shared unit busy");

	// Tap products and reciprocal scale never share the multiplier
	a_mul_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.mul_tap && ctrl.mul_norm))
		else $error("multiplier used twice in one cycle");

	// Magnitude capture is followed by the reciprocal scale
	a_mag_then_scale: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.mag_en |=> ctrl.mul_norm)
		else $error("scale step did not follow magnitude");

	// Accumulator clears only on an accepted push
	a_clr_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.acc_clr |-> (in_valid && in_ready && (opcode == OP_PUSH)))
		else $error("accumulator cleared without a push");

endmodule
